// File: design/assert_macros.svh
// Assertion macros shared by the slab allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: design/scsa_pkg.sv
// Shared types and constants for the size-class slab allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package scsa_pkg;

   localparam int ADDR_W      = 15;     // slot address in 8-byte units
   localparam int LINK_W      = 16;     // valid bit plus next address
   localparam int LINK_DEPTH  = 32768;  // one link per addressable slot
   localparam int SIZE_W      = 8;
   localparam int UNITS_W     = 6;      // rounded unit count, up to 32
   localparam int LIMIT_W     = 7;
   localparam int USED_W      = 7;

   localparam logic [SIZE_W:0]    UNIT_ROUND  = 9'd7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO     = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
   localparam logic [1:0] STATUS_OOM      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;         // input beat taken, class lookup issued
      logic pop_read;       // read the link of the popped slot
      logic commit_lookup;  // finish a request that needs no link read
      logic commit_pop;     // finish a free-list pop
   } scsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_pop;       // looked-up request pops a free slot
      logic out_free;       // result register can take a beat
   } scsa_status_type;

endpackage

// File: design/scsa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module scsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/scsa_ctrl.sv
// Sequencing state machine of the slab allocator.
// Depends on scsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scsa_ctrl
   import scsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  scsa_status_type status,
   output scsa_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_POP    = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (status.head_pop) begin
               cmd.pop_read = 1'b1;
               state_in     = S_POP;
            end else if (status.out_free) begin
               cmd.commit_lookup = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_POP: begin
            if (status.out_free) begin
               cmd.commit_pop = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `ASSERT_CLK(a_cmd_onehot, clock, reset, $onehot0(cmd), "controller issued two commands at once")
   `ASSERT_CLK(a_pop_entry, clock, reset,
      (state_ff == S_POP) |-> ($past(state_ff) == S_LOOKUP || $past(state_ff) == S_POP),
      "pop state entered without a lookup")

endmodule

// File: design/scsa_datapath.sv
// Datapath of the slab allocator: class state, link memory, heap carving, result register.
// Depends on scsa_pkg, scsa_ram and assert_macros.svh.
`include "assert_macros.svh"

module scsa_datapath
   import scsa_pkg::*;
#(
   parameter int NUM_CLASSES = 16,
   parameter int BLOCK_UNITS = 512,
   parameter int HEAP_BLOCKS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  scsa_cmd_type        cmd,
   output scsa_status_type     status,
   input  logic                req_operation,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [ADDR_W-1:0]   req_free_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ADDR_W-1:0]   rsp_slot_address,
   output logic [1:0]          rsp_status,
   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data
);

   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CUR_W = $clog2(HEAP_BLOCKS * BLOCK_UNITS + 1);
   localparam int ENT_W = 1 + ADDR_W + 2 * CUR_W;

   // Decode of the incoming beat.
   logic [SIZE_W:0]    size_sum;
   logic [UNITS_W-1:0] units_in;
   logic               class_ok_in;
   logic [1:0]         code_in;
   logic [CLS_W-1:0]   cls_in;

   assign size_sum    = {1'b0, req_size_bytes} + UNIT_ROUND;
   assign units_in    = size_sum[SIZE_W:3];
   assign class_ok_in = (req_size_bytes != '0) &&
                        ({1'b0, units_in} <= (UNITS_W + 1)'(NUM_CLASSES));
   assign code_in     = (req_size_bytes == '0) ? STATUS_ZERO :
                        (class_ok_in ? STATUS_OK : STATUS_OVERSIZE);
   assign cls_in      = class_ok_in ? CLS_W'(units_in - UNITS_W'(1)) : '0;

   // Request registers, loaded when the beat is accepted.
   logic               op_ff;
   logic [UNITS_W-1:0] units_ff;
   logic [ADDR_W-1:0]  faddr_ff;
   logic [CLS_W-1:0]   cls_ff;
   logic [1:0]         code_ff;
   logic               entry_vld_ff;

   // Per-class entries that were never written read as the reset state.
   logic [NUM_CLASSES-1:0] class_valid_ff;
   logic [NUM_CLASSES-1:0] class_valid_in;

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic [USED_W-1:0]  used_ff;
   logic [USED_W-1:0]  used_in;
   logic [CUR_W-1:0]   base_ff;
   logic [CUR_W-1:0]   base_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [ADDR_W-1:0]  rsp_addr_in;
   logic [1:0]         rsp_status_ff;
   logic [1:0]         rsp_status_in;

   // Memory ports.
   logic               cls_wr_en;
   logic [ENT_W-1:0]   cls_wr_data;
   logic [ENT_W-1:0]   cls_rd_data;
   logic               link_wr_en;
   logic [LINK_W-1:0]  link_wr_data;
   logic [LINK_W-1:0]  link_rd_data;

   // Lookup of the class entry.
   logic [ENT_W-1:0]   entry;
   logic               head_vld;
   logic [ADDR_W-1:0]  head_addr;
   logic [CUR_W-1:0]   cursor;
   logic [CUR_W-1:0]   blk_end;
   logic               is_class;
   logic               is_alloc;
   logic [CUR_W:0]     bump_sum;
   logic               need_block;
   logic [LIMIT_W-1:0] eff_limit;
   logic               too_big;
   logic               oom;
   logic               carve;
   logic [CUR_W-1:0]   grant_addr;
   logic [CUR_W-1:0]   new_cursor;
   logic [CUR_W-1:0]   new_end;
   logic               out_free;

   assign entry     = entry_vld_ff ? cls_rd_data : '0;
   assign head_vld  = entry[ENT_W-1];
   assign head_addr = entry[ENT_W-2 -: ADDR_W];
   assign cursor    = entry[2*CUR_W-1 -: CUR_W];
   assign blk_end   = entry[CUR_W-1:0];

   assign is_class   = (code_ff == STATUS_OK);
   assign is_alloc   = (op_ff == OP_ALLOC);
   assign bump_sum   = {1'b0, cursor} + (CUR_W + 1)'(units_ff);
   assign need_block = bump_sum > {1'b0, blk_end};
   assign eff_limit  = (limit_ff > LIMIT_W'(HEAP_BLOCKS)) ? LIMIT_W'(HEAP_BLOCKS) : limit_ff;
   assign too_big    = 32'(units_ff) > 32'(BLOCK_UNITS);
   assign oom        = need_block && (too_big || (used_ff >= eff_limit));
   assign carve      = cmd.commit_lookup && is_class && is_alloc && need_block && !oom;
   assign grant_addr = need_block ? base_ff : cursor;
   assign new_cursor = grant_addr + CUR_W'(units_ff);
   assign new_end    = need_block ? (base_ff + CUR_W'(BLOCK_UNITS)) : blk_end;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign status.head_pop = is_class && is_alloc && head_vld;
   assign status.out_free = out_free;

   // Class entry and link writes.
   always_comb begin
      cls_wr_en   = cmd.commit_pop ||
                    (cmd.commit_lookup && is_class && !(is_alloc && oom));
      cls_wr_data = {1'b0, head_addr, new_cursor, new_end};
      if (cmd.commit_pop) begin
         cls_wr_data = {link_rd_data, cursor, blk_end};
      end else if (!is_alloc) begin
         cls_wr_data = {1'b1, faddr_ff, cursor, blk_end};
      end
      link_wr_en   = cmd.commit_lookup && is_class && !is_alloc;
      link_wr_data = {head_vld, head_addr};
   end

   scsa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_CLASSES)
   ) u_class_ram (
      .clock   (clock),
      .wr_en   (cls_wr_en),
      .wr_addr (cls_ff),
      .wr_data (cls_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (cls_in),
      .rd_data (cls_rd_data)
   );

   scsa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (faddr_ff),
      .wr_data (link_wr_data),
      .rd_en   (cmd.pop_read),
      .rd_addr (head_addr),
      .rd_data (link_rd_data)
   );

   // Next values of the control registers and the result register.
   always_comb begin
      limit_in       = csr_write_enable ? csr_write_data : limit_ff;
      used_in        = carve ? (used_ff + USED_W'(1)) : used_ff;
      base_in        = carve ? (base_ff + CUR_W'(BLOCK_UNITS)) : base_ff;
      class_valid_in = class_valid_ff;
      if (cls_wr_en) begin
         class_valid_in[cls_ff] = 1'b1;
      end
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.commit_pop) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = head_addr;
         rsp_status_in = STATUS_OK;
      end else if (cmd.commit_lookup) begin
         rsp_valid_in = 1'b1;
         if (!is_class) begin
            rsp_addr_in   = '0;
            rsp_status_in = code_ff;
         end else if (is_alloc && oom) begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_OOM;
         end else if (is_alloc) begin
            rsp_addr_in   = ADDR_W'(grant_addr);
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_RESET;
         used_ff        <= '0;
         base_ff        <= '0;
         class_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         limit_ff       <= limit_in;
         used_ff        <= used_in;
         base_ff        <= base_in;
         class_valid_ff <= class_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_operation;
         units_ff     <= units_in;
         faddr_ff     <= req_free_address;
         cls_ff       <= cls_in;
         code_ff      <= code_in;
         entry_vld_ff <= class_ok_in && class_valid_ff[cls_in];
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   `ASSERT_CLK(a_used_bound, clock, reset, used_ff <= USED_W'(HEAP_BLOCKS),
      "more heap blocks handed out than the heap holds")
   `ASSERT_CLK(a_commit_shows, clock, reset, (cmd.commit_lookup || cmd.commit_pop) |=> rsp_valid_ff,
      "finished request did not reach the result register")

endmodule

// File: design/size_class_slab_allocator_unit.sv
// Top level of the size-class slab allocator.
// Depends on scsa_pkg, scsa_ctrl and scsa_datapath.
//
// Usage: a request beat on req_* carries an operation (allocate or free), a byte
// size and, for frees, the slot address in 8-byte units. Every request beat gives
// exactly one result beat on rsp_*: the granted slot address and a status code
// (ok, zero size, oversize, out of memory). The heap_block_limit register is
// written through csr_write_enable and csr_write_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Sequencing: accepting a request in the idle state issues the class RAM read;
// the result is registered at the end of the lookup state, or, for an allocate
// that pops a free list, at the end of the pop state, after the popped slot's
// link is read from the link RAM. The block holds one request at a time and
// takes the next beat once the current one has been handed to the result register.
// Reset (synchronous, active high) empties all free lists, drops every held block
// and sets the limit to 64; the link RAM needs no clearing.
// When the receiver stalls, the result beat holds on rsp_*; a request taken
// meanwhile waits in its last cycle until the result register frees up.
module size_class_slab_allocator_unit
   import scsa_pkg::*;
#(
   parameter int NUM_CLASSES = 16,
   parameter int BLOCK_UNITS = 512,
   parameter int HEAP_BLOCKS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic [ADDR_W-1:0]  req_free_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_slot_address,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   scsa_cmd_type    cmd;
   scsa_status_type status;

   // The controller sequences accept, lookup, optional link read and commit.
   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns all allocator state and the result register.
   scsa_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .BLOCK_UNITS (BLOCK_UNITS),
      .HEAP_BLOCKS (HEAP_BLOCKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_size_bytes   (req_size_bytes),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_address (rsp_slot_address),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule
